// ===== rtl/bfu_pkg.sv =====
// Shared types, constants and fixed-point helpers for the boids flock update block.
// No dependencies; every other file in rtl/ imports this package.
package bfu_pkg;

    localparam int MAX_BOIDS_DEF = 1024;
    localparam int APB_AW        = 5;
    localparam int DIV_W         = 48;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ARENA_TOP    = 3'd0;
    localparam logic [2:0] REG_ARENA_BOTTOM = 3'd1;
    localparam logic [2:0] REG_ARENA_LEFT   = 3'd2;
    localparam logic [2:0] REG_ARENA_RIGHT  = 3'd3;
    localparam logic [2:0] REG_BIAS_VALUE   = 3'd4;
    localparam logic [2:0] REG_VISION       = 3'd5;
    localparam logic [2:0] REG_GUARD        = 3'd6;
    localparam logic [2:0] REG_BOID_COUNT   = 3'd7;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [1:0] GRP_RIGHT = 2'd1;
    localparam logic [1:0] GRP_LEFT  = 2'd2;

    // s16.15 constants
    localparam logic signed [31:0] TURN_F     = 32'sd6553;
    localparam logic signed [31:0] CENTER_F   = 32'sd16;
    localparam logic signed [31:0] AVOID_F    = 32'sd1638;
    localparam logic signed [31:0] MATCH_F    = 32'sd1638;
    localparam logic signed [31:0] SPEED_MAX  = 32'sd196608;
    localparam logic signed [31:0] SPEED_MIN  = 32'sd98304;
    localparam logic signed [31:0] POINT_FOUR = 32'sd13107;
    localparam logic signed [31:0] ONE_FIX    = 32'sd32768;
    localparam logic signed [31:0] WRAP_Y     = 32'sd15695872;
    localparam logic signed [31:0] WRAP_X     = 32'sd20938752;
    localparam logic [16:0]        BIAS_MAX   = 17'd327;
    localparam logic [16:0]        BIAS_MIN   = 17'd1;

    typedef struct packed {
        logic [1:0]         group;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } boid_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vis;
        logic signed [31:0] vis2;
        logic signed [31:0] grd2;
    } scan_cmd_t;

    typedef struct packed {
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] vxs;
        logic signed [31:0] vys;
        logic signed [31:0] cdx;
        logic signed [31:0] cdy;
    } scan_res_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SQV, S_SQG, S_SCST, S_SCAN, S_DIV, S_DIVW,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_A1, S_A2, S_A3, S_EDGE,
        S_B1, S_B2, S_B3, S_SP1, S_SP2, S_LIM, S_VDIV, S_VDIVW,
        S_VMUL, S_VSTORE, S_MOVE, S_DONE
    } state_t;

    // s16.15 product: floor shift by 15, keep 32 bits
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[46:15];
    endfunction

    // wrapping absolute value
    function automatic logic signed [31:0] wabs(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : a;
    endfunction

endpackage

// ===== rtl/bfu_store.sv =====
// Boid table: one synchronous RAM, one write port, one registered read port.
// Depends on bfu_pkg (boid_t).
module bfu_store #(
    parameter int MAX_BOIDS = bfu_pkg::MAX_BOIDS_DEF,
    localparam int AW = $clog2(MAX_BOIDS)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  bfu_pkg::boid_t wdata,
    input  logic [AW-1:0] raddr,
    output bfu_pkg::boid_t rdata
);
    import bfu_pkg::*;

    boid_t mem [MAX_BOIDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // the sequencer never uses read data taken in a cycle in which it writes the table
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bfu_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on bfu_pkg (DIV_W).
module bfu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [31:0] quot
);
    import bfu_pkg::*;

    localparam int SW = $clog2(DIV_W);

    logic [DIV_W-1:0] num_reg;
    logic [31:0]      den_reg;
    logic [31:0]      rem_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SW-1:0]    step_reg;
    logic [32:0]      rem_sh;
    logic [32:0]      rem_sub;
    logic             fits;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        fits    = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitudes on start, quotient shifts in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[47] ? DIV_W'(-dividend) : DIV_W'(dividend);
            den_reg <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[47] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[31:0] : rem_sh[31:0];
            num_reg <= {num_reg[DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? 32'(-num_reg[31:0]) : num_reg[31:0];

endmodule

// ===== rtl/bfu_scan.sv =====
// Neighbour scan: walks the table one entry a cycle through a three-stage
// pipeline (difference, squares, classify and accumulate). Depends on bfu_pkg.
module bfu_scan #(
    parameter int MAX_BOIDS = bfu_pkg::MAX_BOIDS_DEF,
    localparam int AW = $clog2(MAX_BOIDS),
    localparam int CW = $clog2(MAX_BOIDS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bfu_pkg::scan_cmd_t cmd,
    input  logic [AW-1:0]     self_idx,
    input  logic [CW-1:0]     scan_n,
    output logic [AW-1:0]     raddr,
    input  bfu_pkg::boid_t    rdata,
    output bfu_pkg::scan_res_t res,
    output logic [CW-1:0]     cnt,
    output logic              busy,
    output logic              done
);
    import bfu_pkg::*;

    logic          busy_reg;
    logic          issue_reg;
    logic [CW-1:0] j_reg;
    logic          o0_reg, o1_reg, o2_reg;
    logic          skip0_reg;
    logic          v1_reg, v2_reg;

    logic signed [31:0] dx1_reg, dy1_reg, ox1_reg, oy1_reg, ovx1_reg, ovy1_reg;
    logic signed [31:0] dx2_reg, dy2_reg, ox2_reg, oy2_reg, ovx2_reg, ovy2_reg;
    logic signed [31:0] sqx2_reg, sqy2_reg;

    scan_res_t     acc_reg;
    logic [CW-1:0] cnt_reg;

    logic signed [31:0] dx, dy, d2;
    logic               in_view;

    always_comb
    begin
        dx      = cmd.x - rdata.x;
        dy      = cmd.y - rdata.y;
        in_view = (wabs(dx) < cmd.vis) && (wabs(dy) < cmd.vis);
        d2      = sqx2_reg + sqy2_reg;
    end

    assign done  = busy_reg && !issue_reg && !o0_reg && !o1_reg && !o2_reg;
    assign busy  = busy_reg;
    assign raddr = j_reg[AW-1:0];
    assign res   = acc_reg;
    assign cnt   = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            o0_reg    <= 1'b0;
            o1_reg    <= 1'b0;
            o2_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                issue_reg <= (scan_n != '0);
                j_reg     <= '0;
            end
            else
            begin
                if (done)
                begin
                    busy_reg <= 1'b0;
                end
                if (issue_reg)
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == scan_n - 1'b1)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
            end
            o0_reg <= issue_reg && !cmd.start;
            o1_reg <= o0_reg;
            o2_reg <= o1_reg;
            v1_reg <= o0_reg && !skip0_reg && in_view;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        skip0_reg <= (j_reg == CW'(self_idx));
        dx1_reg   <= dx;
        dy1_reg   <= dy;
        ox1_reg   <= rdata.x;
        oy1_reg   <= rdata.y;
        ovx1_reg  <= rdata.vx;
        ovy1_reg  <= rdata.vy;
        sqx2_reg  <= fmul(dx1_reg, dx1_reg);
        sqy2_reg  <= fmul(dy1_reg, dy1_reg);
        dx2_reg   <= dx1_reg;
        dy2_reg   <= dy1_reg;
        ox2_reg   <= ox1_reg;
        oy2_reg   <= oy1_reg;
        ovx2_reg  <= ovx1_reg;
        ovy2_reg  <= ovy1_reg;
        if (cmd.start)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (v2_reg)
        begin
            if (d2 < cmd.grd2)
            begin
                acc_reg.cdx <= acc_reg.cdx + dx2_reg;
                acc_reg.cdy <= acc_reg.cdy + dy2_reg;
            end
            else if (d2 < cmd.vis2)
            begin
                acc_reg.xs  <= acc_reg.xs + ox2_reg;
                acc_reg.ys  <= acc_reg.ys + oy2_reg;
                acc_reg.vxs <= acc_reg.vxs + ovx2_reg;
                acc_reg.vys <= acc_reg.vys + ovy2_reg;
                cnt_reg     <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/boids_flock_update.sv =====
// Top level of the boids flock update block: APB registers, request sequencer,
// shared multiplier. Depends on bfu_pkg, bfu_store, bfu_div and bfu_scan.
//
// The block holds a table of MAX_BOIDS boids (s16.15 position and velocity,
// two-bit group) in one synchronous RAM. A write beat (tuser = 0) stores an
// entry and returns it from the output register; an update beat (tuser = 1)
// reads the entry, wraps it when the arena is the full screen, scans the
// first boid_count entries for separation, alignment and cohesion, applies
// edge turning, group bias and the speed limit, writes the entry back and
// returns it. One request is in flight at a time: an update's run time is set
// by the scan of the RAM read port, one entry a cycle, plus up to six serial
// divisions (four neighbour averages, two speed scalings). A finished result
// sits in the output register, so the next request is taken while it waits.
// Reading an entry never written returns whatever the RAM holds. Configure
// only while no request is in flight.
module boids_flock_update #(
    parameter int MAX_BOIDS = bfu_pkg::MAX_BOIDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfu_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // boid_index[9:0], in_x[41:10], in_y[73:42], in_vx[105:74],
    // in_vy[137:106], in_group[139:138], zero[143:140]
    input  logic [143:0]               s_tdata,
    // req_type[0]
    input  logic                       s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_index[9:0], out_x[41:10], out_y[73:42], out_vx[105:74],
    // out_vy[137:106], out_group[139:138], zero[143:140]
    output logic [143:0]               m_tdata
);
    import bfu_pkg::*;

    localparam int AW = $clog2(MAX_BOIDS);
    localparam int CW = $clog2(MAX_BOIDS + 1);

    // ---------------------------------------------------------------- config
    logic [8:0]  cfg_top_reg, cfg_bottom_reg;
    logic [9:0]  cfg_left_reg, cfg_right_reg;
    logic [15:0] cfg_bias_reg;
    logic [23:0] cfg_vis_reg, cfg_grd_reg;
    logic [10:0] cfg_count_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_top_reg    <= 9'd100;
            cfg_bottom_reg <= 9'd380;
            cfg_left_reg   <= 10'd100;
            cfg_right_reg  <= 10'd540;
            cfg_bias_reg   <= 16'd32;
            cfg_vis_reg    <= 24'd1310720;
            cfg_grd_reg    <= 24'd262144;
            cfg_count_reg  <= 11'd700;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ARENA_TOP:    cfg_top_reg    <= pwdata[8:0];
                REG_ARENA_BOTTOM: cfg_bottom_reg <= pwdata[8:0];
                REG_ARENA_LEFT:   cfg_left_reg   <= pwdata[9:0];
                REG_ARENA_RIGHT:  cfg_right_reg  <= pwdata[9:0];
                REG_BIAS_VALUE:   cfg_bias_reg   <= pwdata[15:0];
                REG_VISION:       cfg_vis_reg    <= pwdata[23:0];
                REG_GUARD:        cfg_grd_reg    <= pwdata[23:0];
                REG_BOID_COUNT:   cfg_count_reg  <= pwdata[10:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_ARENA_TOP:    prdata = 32'(cfg_top_reg);
            REG_ARENA_BOTTOM: prdata = 32'(cfg_bottom_reg);
            REG_ARENA_LEFT:   prdata = 32'(cfg_left_reg);
            REG_ARENA_RIGHT:  prdata = 32'(cfg_right_reg);
            REG_BIAS_VALUE:   prdata = 32'(cfg_bias_reg);
            REG_VISION:       prdata = 32'(cfg_vis_reg);
            REG_GUARD:        prdata = 32'(cfg_grd_reg);
            REG_BOID_COUNT:   prdata = 32'(cfg_count_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input
    logic [9:0]         in_idx;
    logic signed [31:0] in_x, in_y, in_vx, in_vy;
    logic [1:0]         in_group;
    logic               in_beat, in_range;

    assign in_idx   = s_tdata[9:0];
    assign in_x     = s_tdata[41:10];
    assign in_y     = s_tdata[73:42];
    assign in_vx    = s_tdata[105:74];
    assign in_vy    = s_tdata[137:106];
    assign in_group = s_tdata[139:138];
    assign in_beat  = s_tvalid && s_tready;
    assign in_range = (32'(in_idx) < 32'(MAX_BOIDS));

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [9:0]         idx_reg;
    logic signed [31:0] x_reg, y_reg, vx_reg, vy_reg;
    logic [1:0]         g_reg;
    logic signed [31:0] vis2_reg, grd2_reg, mul_reg, tmp_reg;
    logic signed [31:0] xa_reg, ya_reg, vxa_reg, vya_reg;
    logic [16:0]        bgain_reg;
    logic signed [31:0] mx_reg, speed_reg, lim_reg, q_reg;
    logic [1:0]         k_reg;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [143:0]  m_tdata_reg;
    logic          out_load;

    // RAM
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    boid_t         mem_wdata, mem_rdata;

    // scan
    scan_cmd_t     scan_cmd;
    scan_res_t     scan_res;
    logic [CW-1:0] scan_cnt, scan_n;
    logic [AW-1:0] scan_raddr;
    logic          scan_busy, scan_done;

    // divider and multiplier
    logic               div_start, div_done;
    logic signed [47:0] div_a;
    logic signed [31:0] div_b, div_quot;
    logic signed [31:0] mul_a, mul_b;

    // combinational helpers
    logic signed [31:0] y_w1, y_w2, x_w1, x_w2;
    logic signed [31:0] vx_edge, vy_edge;
    logic [17:0]        bias_up, bias_dn;
    logic [16:0]        bias_sel;
    logic               bias_grow;
    logic signed [31:0] abs_x, abs_y, sp_max, sp_min;
    logic               full_h, full_w;

    bfu_store #(.MAX_BOIDS(MAX_BOIDS)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bfu_scan #(.MAX_BOIDS(MAX_BOIDS)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (scan_cmd),
        .self_idx (AW'(idx_reg)),
        .scan_n   (scan_n),
        .raddr    (scan_raddr),
        .rdata    (mem_rdata),
        .res      (scan_res),
        .cnt      (scan_cnt),
        .busy     (scan_busy),
        .done     (scan_done)
    );

    bfu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quot     (div_quot)
    );

    // boid_count above the table size scans the whole table
    assign scan_n = (32'(cfg_count_reg) > 32'(MAX_BOIDS)) ? CW'(MAX_BOIDS)
                                                          : CW'(cfg_count_reg);

    always_comb
    begin
        scan_cmd.start = (state_reg == S_SCST);
        scan_cmd.x     = x_reg;
        scan_cmd.y     = y_reg;
        scan_cmd.vis   = 32'(cfg_vis_reg);
        scan_cmd.vis2  = vis2_reg;
        scan_cmd.grd2  = grd2_reg;
    end

    assign mem_raddr = scan_busy ? scan_raddr : AW'(in_idx);
    assign mem_waddr = (state_reg == S_IDLE) ? AW'(in_idx) : AW'(idx_reg);

    // wrap for the full-screen arena, edge turning, bias and speed helpers
    always_comb
    begin
        full_h = (cfg_top_reg == 9'd0) && (cfg_bottom_reg == 9'd480);
        full_w = (cfg_left_reg == 10'd0) && (cfg_right_reg == 10'd640);
        y_w1   = (full_h && mem_rdata.y >= WRAP_Y) ? mem_rdata.y - WRAP_Y : mem_rdata.y;
        y_w2   = (full_h && y_w1 <= 32'sd0) ? y_w1 + WRAP_Y : y_w1;
        x_w1   = (full_w && mem_rdata.x >= WRAP_X) ? mem_rdata.x - WRAP_X : mem_rdata.x;
        x_w2   = (full_w && x_w1 <= 32'sd0) ? x_w1 + WRAP_X : x_w1;

        vy_edge = vy_reg;
        if (y_reg < $signed({8'b0, cfg_top_reg, 15'b0}))
        begin
            vy_edge = vy_edge + TURN_F;
        end
        if (y_reg > $signed({8'b0, cfg_bottom_reg, 15'b0}))
        begin
            vy_edge = vy_edge - TURN_F;
        end
        vx_edge = vx_reg;
        if (x_reg > $signed({7'b0, cfg_right_reg, 15'b0}))
        begin
            vx_edge = vx_edge - TURN_F;
        end
        if (x_reg < $signed({7'b0, cfg_left_reg, 15'b0}))
        begin
            vx_edge = vx_edge + TURN_F;
        end

        // group 1 grows the bias while moving right, group 2 while moving left
        bias_grow = (g_reg == GRP_RIGHT) ? (vx_reg > 32'sd0) : vx_reg[31];
        bias_up   = {2'b0, cfg_bias_reg} + 18'd1;
        bias_dn   = {2'b0, cfg_bias_reg} - 18'd1;
        if (bias_grow)
        begin
            bias_sel = (bias_up > 18'(BIAS_MAX)) ? BIAS_MAX : bias_up[16:0];
        end
        else
        begin
            bias_sel = ($signed(bias_dn) < $signed(18'(BIAS_MIN))) ? BIAS_MIN
                                                                   : bias_dn[16:0];
        end

        abs_x  = wabs(vx_reg);
        abs_y  = wabs(vy_reg);
        sp_max = (abs_x > abs_y) ? abs_x : abs_y;
        sp_min = (abs_x < abs_y) ? abs_x : abs_y;
    end

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_LOAD:
            begin
                mul_a = 32'(cfg_vis_reg);
                mul_b = 32'(cfg_vis_reg);
            end
            S_SQV:
            begin
                mul_a = 32'(cfg_grd_reg);
                mul_b = 32'(cfg_grd_reg);
            end
            S_C1:
            begin
                mul_a = xa_reg - x_reg;
                mul_b = CENTER_F;
            end
            S_C2:
            begin
                mul_a = vxa_reg - vx_reg;
                mul_b = MATCH_F;
            end
            S_C3:
            begin
                mul_a = ya_reg - y_reg;
                mul_b = CENTER_F;
            end
            S_C4:
            begin
                mul_a = vya_reg - vy_reg;
                mul_b = MATCH_F;
            end
            S_A1:
            begin
                mul_a = scan_res.cdx;
                mul_b = AVOID_F;
            end
            S_A2:
            begin
                mul_a = scan_res.cdy;
                mul_b = AVOID_F;
            end
            S_B2:
            begin
                mul_a = ONE_FIX - 32'(bgain_reg);
                mul_b = vx_reg;
            end
            S_SP1:
            begin
                mul_a = POINT_FOUR;
                mul_b = sp_min;
            end
            S_VMUL:
            begin
                mul_a = q_reg;
                mul_b = lim_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operands: neighbour averages, then (v << 15) / speed
    always_comb
    begin
        if (state_reg == S_VDIV)
        begin
            div_a = (k_reg == 2'd0) ? {vx_reg[31], vx_reg, 15'b0}
                                    : {vy_reg[31], vy_reg, 15'b0};
            div_b = speed_reg;
        end
        else
        begin
            case (k_reg)
                2'd0:    div_a = 48'(scan_res.xs);
                2'd1:    div_a = 48'(scan_res.ys);
                2'd2:    div_a = 48'(scan_res.vxs);
                default: div_a = 48'(scan_res.vys);
            endcase
            div_b = 32'(scan_cnt);
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = '{group: in_group, vy: in_vy, vx: in_vx, y: in_y, x: in_x};
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_beat)
                begin
                    mem_we = in_range && (s_tuser == REQ_WRITE);
                    state_next = (in_range && s_tuser == REQ_UPDATE) ? S_LOAD : S_DONE;
                end
            end
            S_LOAD:  state_next = S_SQV;
            S_SQV:   state_next = S_SQG;
            S_SQG:   state_next = S_SCST;
            S_SCST:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = (scan_cnt != '0) ? S_DIV : S_A1;
                end
            end
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = (k_reg == 2'd3) ? S_C1 : S_DIV;
                end
            end
            S_C1:    state_next = S_C2;
            S_C2:    state_next = S_C3;
            S_C3:    state_next = S_C4;
            S_C4:    state_next = S_C5;
            S_C5:    state_next = S_A1;
            S_A1:    state_next = S_A2;
            S_A2:    state_next = S_A3;
            S_A3:    state_next = S_EDGE;
            S_EDGE:
            begin
                state_next = (g_reg == GRP_RIGHT || g_reg == GRP_LEFT) ? S_B1 : S_SP1;
            end
            S_B1:    state_next = S_B2;
            S_B2:    state_next = S_B3;
            S_B3:    state_next = S_SP1;
            S_SP1:   state_next = S_SP2;
            S_SP2:   state_next = S_LIM;
            S_LIM:
            begin
                if (speed_reg != 32'sd0 && (speed_reg < SPEED_MIN || speed_reg > SPEED_MAX))
                begin
                    state_next = S_VDIV;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_VDIV:
            begin
                div_start  = 1'b1;
                state_next = S_VDIVW;
            end
            S_VDIVW:
            begin
                if (div_done)
                begin
                    state_next = S_VMUL;
                end
            end
            S_VMUL:  state_next = S_VSTORE;
            S_VSTORE:
            begin
                state_next = (k_reg == 2'd0) ? S_VDIV : S_MOVE;
            end
            S_MOVE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{group: g_reg, vy: vy_reg, vx: vx_reg,
                               y: y_reg + vy_reg, x: x_reg + vx_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= fmul(mul_a, mul_b);
        if (out_load)
        begin
            m_tdata_reg <= {4'b0, g_reg, vy_reg, vx_reg, y_reg, x_reg, idx_reg};
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    idx_reg <= in_idx;
                    if (!in_range)
                    begin
                        x_reg  <= '0;
                        y_reg  <= '0;
                        vx_reg <= '0;
                        vy_reg <= '0;
                        g_reg  <= '0;
                    end
                    else
                    begin
                        x_reg  <= in_x;
                        y_reg  <= in_y;
                        vx_reg <= in_vx;
                        vy_reg <= in_vy;
                        g_reg  <= in_group;
                    end
                end
            end
            S_LOAD:
            begin
                x_reg  <= x_w2;
                y_reg  <= y_w2;
                vx_reg <= mem_rdata.vx;
                vy_reg <= mem_rdata.vy;
                g_reg  <= mem_rdata.group;
            end
            S_SQV:   vis2_reg <= mul_reg;
            S_SQG:   grd2_reg <= mul_reg;
            S_SCAN:  k_reg <= 2'd0;
            S_DIVW:
            begin
                if (div_done)
                begin
                    case (k_reg)
                        2'd0:    xa_reg  <= div_quot;
                        2'd1:    ya_reg  <= div_quot;
                        2'd2:    vxa_reg <= div_quot;
                        default: vya_reg <= div_quot;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end
            end
            S_C2:    tmp_reg <= vx_reg + mul_reg;
            S_C3:    vx_reg  <= tmp_reg + mul_reg;
            S_C4:    tmp_reg <= vy_reg + mul_reg;
            S_C5:    vy_reg  <= tmp_reg + mul_reg;
            S_A2:    vx_reg  <= vx_reg + mul_reg;
            S_A3:    vy_reg  <= vy_reg + mul_reg;
            S_EDGE:
            begin
                vx_reg <= vx_edge;
                vy_reg <= vy_edge;
            end
            S_B1:    bgain_reg <= bias_sel;
            S_B3:
            begin
                vx_reg <= (g_reg == GRP_RIGHT) ? mul_reg + 32'(bgain_reg)
                                               : mul_reg - 32'(bgain_reg);
            end
            S_SP1:   mx_reg <= sp_max;
            S_SP2:   speed_reg <= mx_reg + mul_reg;
            S_LIM:
            begin
                lim_reg <= (speed_reg < SPEED_MIN) ? SPEED_MIN : SPEED_MAX;
                k_reg   <= 2'd0;
            end
            S_VDIVW:
            begin
                if (div_done)
                begin
                    q_reg <= div_quot;
                end
            end
            S_VSTORE:
            begin
                if (k_reg == 2'd0)
                begin
                    vx_reg <= mul_reg;
                    k_reg  <= 2'd1;
                end
                else
                begin
                    vy_reg <= mul_reg;
                end
            end
            S_MOVE:
            begin
                x_reg <= x_reg + vx_reg;
                y_reg <= y_reg + vy_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- checks
    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == S_SCAN))
        else $error("scan finished outside the scan wait");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVW || state_reg == S_VDIVW))
        else $error("divider finished with nobody waiting");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !scan_busy)
        else $error("table written during a neighbour scan");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not presented after completion");

endmodule
